// ----- design/text_console_writer_defines.svh -----
// assertion macros shared by the text console writer checker
// clocked on aclk, quiet while aresetn is low; no other dependencies
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define CTW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CTW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ctw_pkg.sv -----
// shared types and constants of the text console writer
// no dependencies
package ctw_pkg;

    localparam int unsigned ACTION_W  = 2;
    localparam int unsigned CODE_W    = 8;
    localparam int unsigned ADDR_W    = 11;
    localparam int unsigned POS_W     = 11;
    localparam int unsigned CELL_W    = 16;
    localparam int unsigned ATTR_W    = 8;
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 32;

    localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CODE_W-1:0] BLANK_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h01;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2
    } ctw_action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUT,
        ST_COPY,
        ST_FILL,
        ST_CLEAR,
        ST_READ,
        ST_EMIT
    } ctw_state_t;

    typedef struct packed {
        ctw_action_t       action;
        logic [CODE_W-1:0] char_code;
        logic [ADDR_W-1:0] cell_address;
    } ctw_item_t;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_position;
        logic [CELL_W-1:0] cell_data;
        logic              did_scroll;
    } ctw_result_t;

endpackage

// ----- design/ctw_cell_ram.sv -----
// single-port-write, single-port-read cell store with registered read data
// depends on nothing; contents undefined until written
module ctw_cell_ram #(
    parameter int unsigned DEPTH  = 2000,
    parameter int unsigned ADDR_W = $clog2(DEPTH),
    parameter int unsigned DATA_W = 16
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/ctw_sequencer.sv -----
// action sequencer of the text console writer: cursor, scroll and clear walks
// depends on ctw_pkg; drives the ports of ctw_cell_ram
module ctw_sequencer #(
    parameter int unsigned COLUMNS = 80,
    parameter int unsigned ROWS    = 25,
    parameter int unsigned CELLS   = COLUMNS * ROWS,
    parameter int unsigned AW      = $clog2(CELLS)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    output logic                item_ready,
    input  ctw_pkg::ctw_item_t  item,
    input  logic [7:0]          attr,
    input  logic                out_free,
    output logic                res_valid,
    output ctw_pkg::ctw_result_t res,
    output logic                ram_we,
    output logic [AW-1:0]       ram_waddr,
    output logic [15:0]         ram_wdata,
    output logic                ram_re,
    output logic [AW-1:0]       ram_raddr,
    input  logic [15:0]         ram_rdata
);
    import ctw_pkg::*;

    localparam int unsigned CW   = $clog2(CELLS + 1);
    localparam int unsigned RW   = $clog2(ROWS + 1);
    localparam int unsigned COLW = $clog2(COLUMNS);
    localparam int unsigned SPAN = CELLS - COLUMNS;
    localparam int unsigned XW   = AW + ADDR_W;
    localparam int unsigned PW   = CW + POS_W;

    ctw_state_t        state_reg, state_next;
    logic [CW-1:0]     cursor_reg, cursor_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [COLW-1:0]   col_reg, col_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic              addr_ok_reg, addr_ok_next;
    logic              scrolled_reg, scrolled_next;

    logic [XW-1:0]     addr_ext;
    logic              addr_ok;
    logic              past_end;
    logic [PW-1:0]     pos_ext;
    logic [CELL_W-1:0] blank_cell;
    logic [CELL_W-1:0] char_cell;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cursor_reg   <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            cnt_reg      <= '0;
            scrolled_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cursor_reg   <= cursor_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            cnt_reg      <= cnt_next;
            scrolled_reg <= scrolled_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg    <= code_next;
        addr_ok_reg <= addr_ok_next;
    end

    assign addr_ext   = {{AW{1'b0}}, item.cell_address};
    assign addr_ok    = addr_ext < XW'(CELLS);
    assign past_end   = row_reg == RW'(ROWS);
    assign blank_cell = {attr, BLANK_CODE};
    assign char_cell  = {attr, code_reg};
    assign item_ready = state_reg == ST_IDLE;

    always_comb begin
        state_next    = state_reg;
        cursor_next   = cursor_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        cnt_next      = cnt_reg;
        code_next     = code_reg;
        addr_ok_next  = addr_ok_reg;
        scrolled_next = scrolled_reg;
        ram_we        = 1'b0;
        ram_waddr     = cnt_reg;
        ram_wdata     = blank_cell;
        ram_re        = 1'b0;
        ram_raddr     = addr_ext[AW-1:0];
        res_valid     = 1'b0;
        res.cell_data  = '0;
        res.did_scroll = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    code_next     = item.char_code;
                    addr_ok_next  = addr_ok;
                    scrolled_next = 1'b0;
                    cnt_next      = '0;
                    unique case (item.action)
                        ACT_PUT: begin
                            if (past_end) begin
                                scrolled_next = 1'b1;
                                state_next    = ST_COPY;
                            end else begin
                                state_next = ST_PUT;
                            end
                        end
                        ACT_CLEAR: state_next = ST_CLEAR;
                        ACT_READ: begin
                            ram_re     = 1'b1;
                            state_next = ST_READ;
                        end
                        default: state_next = ST_EMIT;
                    endcase
                end
            end
            ST_PUT: begin
                if (out_free) begin
                    res_valid      = 1'b1;
                    res.did_scroll = scrolled_reg;
                    state_next     = ST_IDLE;
                    if (code_reg == NEWLINE_CODE) begin
                        cursor_next = cursor_reg + CW'(COLUMNS) - CW'(col_reg);
                        row_next    = row_reg + RW'(1);
                        col_next    = '0;
                    end else begin
                        ram_we      = 1'b1;
                        ram_waddr   = cursor_reg[AW-1:0];
                        ram_wdata   = char_cell;
                        cursor_next = cursor_reg + CW'(1);
                        if (col_reg == COLW'(COLUMNS - 1)) begin
                            col_next = '0;
                            row_next = row_reg + RW'(1);
                        end else begin
                            col_next = col_reg + COLW'(1);
                        end
                    end
                end
            end
            ST_COPY: begin
                // read one row ahead, write back the cell read last cycle
                if (cnt_reg != AW'(SPAN)) begin
                    ram_re    = 1'b1;
                    ram_raddr = cnt_reg + AW'(COLUMNS);
                end
                if (cnt_reg != '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg - AW'(1);
                    ram_wdata = ram_rdata;
                end
                if (cnt_reg == AW'(SPAN)) begin
                    state_next = ST_FILL;
                end else begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            ST_FILL: begin
                ram_we = 1'b1;
                if (cnt_reg == AW'(CELLS - 1)) begin
                    cursor_next = CW'(SPAN);
                    row_next    = RW'(ROWS - 1);
                    col_next    = '0;
                    state_next  = ST_PUT;
                end else begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            ST_CLEAR: begin
                ram_we = 1'b1;
                if (cnt_reg == AW'(CELLS - 1)) begin
                    cursor_next = '0;
                    row_next    = '0;
                    col_next    = '0;
                    state_next  = ST_EMIT;
                end else begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            ST_READ: begin
                if (out_free) begin
                    res_valid     = 1'b1;
                    res.cell_data = addr_ok_reg ? ram_rdata : '0;
                    state_next    = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        pos_ext             = {{POS_W{1'b0}}, cursor_next};
        res.cursor_position = pos_ext[POS_W-1:0];
    end

endmodule

// ----- design/text_console_writer.sv -----
// top level of the text console writer: stream ports, attribute register,
// result register; depends on ctw_pkg, ctw_sequencer and ctw_cell_ram
//
// channel   | dir | fields (lsb first)                         | handshake
// ----------+-----+--------------------------------------------+------------------
// s_        | in  | tuser: action; tdata: char_code, address   | s_tvalid/s_tready
// m_        | out | tdata: cursor, cell_data, did_scroll       | m_tvalid/m_tready
// cfg_      | in  | wr_data: text attribute                    | cfg_wr_en
//
// put, read and the idle action are accepted, then finished; clear blanks every cell
// before finishing, and a put that scrolls first copies each row up and blanks the
// bottom row; the cell store moves or blanks one cell a cycle on its one write port
// one word is worked on at a time; the next is taken while the result still waits
// in the output register, and a finishing word holds until that register is free
// reset homes the cursor and sets the attribute to 1; cell contents are undefined
// until cleared or written, so no clearing walk follows reset
module text_console_writer #(
    parameter int unsigned COLUMNS = 80,
    parameter int unsigned ROWS    = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [ctw_pkg::S_TDATA_W-1:0] s_tdata,  // char_code[7:0], cell_address[18:8]
    input  logic [ctw_pkg::ACTION_W-1:0]  s_tuser,  // action[1:0]
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [ctw_pkg::M_TDATA_W-1:0] m_tdata,  // cursor_position[10:0],
                                                    // cell_data[26:11], did_scroll[27]
    // attribute register write
    input  logic        cfg_wr_en,
    input  logic [ctw_pkg::ATTR_W-1:0]    cfg_wr_data
);
    import ctw_pkg::*;

    localparam int unsigned CELLS = COLUMNS * ROWS;
    localparam int unsigned AW    = $clog2(CELLS);

    logic [ATTR_W-1:0] attr_reg;
    logic              m_tvalid_reg;
    ctw_result_t       m_result_reg;

    ctw_item_t         item;
    ctw_result_t       res;
    logic              res_valid;
    logic              out_free;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    // colour attribute for every stored or blanked cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= ATTR_RESET;
        end else if (cfg_wr_en) begin
            attr_reg <= cfg_wr_data;
        end
    end

    // unpack the input word
    assign item.action       = ctw_action_t'(s_tuser);
    assign item.char_code    = s_tdata[CODE_W-1:0];
    assign item.cell_address = s_tdata[CODE_W+ADDR_W-1:CODE_W];

    // output register frees up in the same cycle it is drained
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_result_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_result_reg.did_scroll, m_result_reg.cell_data,
                       m_result_reg.cursor_position};

    ctw_sequencer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .CELLS   (CELLS),
        .AW      (AW)
    ) u_sequencer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s_tvalid),
        .item_ready (s_tready),
        .item       (item),
        .attr       (attr_reg),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    // the cell store itself
    ctw_cell_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (AW),
        .DATA_W (CELL_W)
    ) u_cell_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

endmodule

// ----- design/ctw_port_checker.sv -----
// port-level checks for the text console writer, bound to the top level
// depends on ctw_pkg and text_console_writer_defines.svh
`include "text_console_writer_defines.svh"

module ctw_port_checker #(
    parameter int unsigned COLUMNS = 80,
    parameter int unsigned ROWS    = 25
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [ctw_pkg::M_TDATA_W-1:0] m_tdata
);
    import ctw_pkg::*;

    localparam int unsigned CELLS = COLUMNS * ROWS;
    localparam logic [POS_W-1:0] END_POS        = POS_W'(CELLS);
    localparam logic [POS_W-1:0] SCROLL_PUT_POS = POS_W'(CELLS - COLUMNS + 1);
    localparam logic             CURSOR_FITS    = CELLS < (1 << POS_W);

    // a held result must not change
    `CTW_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // one word at a time: no accept in the cycle after an accept
    `CTW_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "input accepted while busy")

    // a scrolling put lands on the bottom row or just past it, with no cell data
    `CTW_ASSERT_NOW(a_scroll_result, m_tvalid && m_tdata[27], (m_tdata[10:0] == SCROLL_PUT_POS || m_tdata[10:0] == END_POS) && m_tdata[26:11] == 16'd0, "bad cursor after scroll")

    // cursor never runs beyond the cell count
    `CTW_ASSERT_NOW(a_cursor_range, m_tvalid && CURSOR_FITS, m_tdata[10:0] <= END_POS, "cursor past cell count")

endmodule

bind text_console_writer ctw_port_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_ctw_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- bench/text_console_writer_tb.sv -----
`timescale 1ns / 100ps
// self-checking bench for text_console_writer: a short table of directed words,
// then random phases under several attribute settings; needs ctw_pkg and the rtl
module text_console_writer_tb;
    import ctw_pkg::*;

    localparam int unsigned COLUMNS      = 80;
    localparam int unsigned ROWS         = 25;
    localparam int unsigned CELLS        = COLUMNS * ROWS;
    localparam int unsigned ADDR_TOP     = (1 << ADDR_W) - 1;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;  // spare code, block just reports
    localparam int unsigned IDLE_PCT     = 19;
    localparam int unsigned RANDOM_WORDS = 1650;
    localparam int unsigned PHASES       = 6;
    localparam int unsigned SETTLE_WAIT  = 16;
    // worst case is a scroll per word plus stalls, taken several times over
    localparam longint unsigned CYCLE_LIMIT = 64'd20_000_000;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [CODE_W-1:0]   code;
        logic [ADDR_W-1:0]   addr;
    } console_word_t;

    typedef struct {
        console_word_t word;
        int unsigned   repeats;
        bit            typed;   // expected result given in the row itself
        ctw_result_t   result;
    } directed_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [ACTION_W-1:0]  s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [ATTR_W-1:0]    cfg_wr_data = '0;

    // shadow of the console: cell contents, which cells hold known data, cursor, attribute
    logic [CELL_W-1:0] shadow_cells [CELLS];
    bit                cell_known [CELLS];
    int unsigned       shadow_cursor = 0;
    logic [ATTR_W-1:0] shadow_attr = ATTR_RESET;

    ctw_result_t   expected_results [$];
    directed_row_t directed_rows [$];
    int unsigned   fail_count = 0;
    longint unsigned cycle_count = 0;
    bit            quiet_run = 1'b0;   // no idling on either side while set

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // works out the result of one word and moves the shadow console on
    function automatic ctw_result_t console_predict(input console_word_t w);
        ctw_result_t r;
        int unsigned i;
        r = '0;
        case (w.action)
            ACT_PUT: begin
                // cursor past the last cell: everything moves up a row first
                if (shadow_cursor >= CELLS) begin
                    for (i = 0; i < CELLS - COLUMNS; i++) begin
                        shadow_cells[i] = shadow_cells[i + COLUMNS];
                        cell_known[i]   = cell_known[i + COLUMNS];
                    end
                    for (i = CELLS - COLUMNS; i < CELLS; i++) begin
                        shadow_cells[i] = {shadow_attr, BLANK_CODE};
                        cell_known[i]   = 1'b1;
                    end
                    shadow_cursor = CELLS - COLUMNS;
                    r.did_scroll  = 1'b1;
                end
                if (w.code == NEWLINE_CODE) begin
                    shadow_cursor = (shadow_cursor / COLUMNS + 1) * COLUMNS;
                end else begin
                    shadow_cells[shadow_cursor] = {shadow_attr, w.code};
                    cell_known[shadow_cursor]   = 1'b1;
                    shadow_cursor++;
                end
            end
            ACT_CLEAR: begin
                for (i = 0; i < CELLS; i++) begin
                    shadow_cells[i] = {shadow_attr, BLANK_CODE};
                    cell_known[i]   = 1'b1;
                end
                shadow_cursor = 0;
            end
            ACT_READ: begin
                if (w.addr < CELLS)
                    r.cell_data = shadow_cells[w.addr];
            end
            default: begin
            end
        endcase
        r.cursor_position = shadow_cursor[POS_W-1:0];
        return r;
    endfunction

    // one random word; newline_odds sets how often a put is a newline
    function automatic console_word_t random_word(input int unsigned newline_odds);
        console_word_t w;
        int unsigned pick;
        w.code = CODE_W'($urandom_range(255));
        w.addr = ADDR_W'($urandom_range(ADDR_TOP));
        pick   = $urandom_range(999);
        if (pick < 3) begin
            w.action = ACT_CLEAR;
        end else if (pick < 25) begin
            w.action = ACT_UNUSED;
        end else if (pick < 155) begin
            w.action = ACT_READ;
            pick = $urandom_range(9);
            if (pick == 0)
                w.addr = ADDR_W'($urandom_range(ADDR_TOP, CELLS));
            else if (pick < 5 && shadow_cursor > 0)
                w.addr = ADDR_W'(shadow_cursor - 1);   // the cell just written
            else
                w.addr = ADDR_W'($urandom_range(CELLS - 1));
            // never read a cell that holds nothing defined yet
            if (w.addr < CELLS && !cell_known[w.addr])
                w.addr = ADDR_W'($urandom_range(ADDR_TOP, CELLS));
        end else begin
            w.action = ACT_PUT;
            if ($urandom_range(newline_odds - 1) == 0)
                w.code = NEWLINE_CODE;
        end
        return w;
    endfunction

    task automatic add_row(input logic [ACTION_W-1:0] action, input logic [CODE_W-1:0] code,
                           input logic [ADDR_W-1:0] addr, input int unsigned repeats,
                           input bit typed, input logic [POS_W-1:0] cursor,
                           input logic [CELL_W-1:0] cell_value, input logic scrolled);
        directed_row_t row;
        row.word.action = action;
        row.word.code   = code;
        row.word.addr   = addr;
        row.repeats     = repeats;
        row.typed       = typed;
        row.result.cursor_position = cursor;
        row.result.cell_data       = cell_value;
        row.result.did_scroll      = scrolled;
        directed_rows.push_back(row);
    endtask

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(input console_word_t w, input bit typed, input ctw_result_t want);
        ctw_result_t predicted;
        while (!quiet_run && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = w.action;
        s_tdata  = {{(S_TDATA_W - ADDR_W - CODE_W){1'b0}}, w.addr, w.code};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        // word taken on this edge: the shadow always moves on, typed rows set the expectation
        predicted = console_predict(w);
        expected_results.push_back(typed ? want : predicted);
        @(negedge aclk);
    endtask

    // sender holds off until every result is back and the block has settled
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        shadow_attr = value;
    endtask

    // receiver stalls at random, decided at the falling edge
    always @(negedge aclk) begin
        m_tready <= quiet_run || ($urandom_range(99) >= IDLE_PCT);
    end

    // result words are compared field by field with the oldest expectation
    always @(posedge aclk) begin : result_check
        ctw_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result word %h arrived with nothing expected", $time, m_tdata);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[POS_W-1:0] !== want.cursor_position) begin
                    $display("%0t: cursor_position expected %0d got %0d", $time,
                             want.cursor_position, m_tdata[POS_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[POS_W+CELL_W-1:POS_W] !== want.cell_data) begin
                    $display("%0t: cell_data expected %h got %h", $time,
                             want.cell_data, m_tdata[POS_W+CELL_W-1:POS_W]);
                    fail_count++;
                end
                if (m_tdata[POS_W+CELL_W] !== want.did_scroll) begin
                    $display("%0t: did_scroll expected %b got %b", $time,
                             want.did_scroll, m_tdata[POS_W+CELL_W]);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        console_word_t w;
        int unsigned   newline_odds;
        logic [ATTR_W-1:0] attr;

        // directed table; attribute still at its reset value of 1 throughout
        // unused action straight after reset: cursor home, nothing else
        add_row(ACT_UNUSED, 8'hFF, 11'h7FF, 1, 1'b1, 11'd0, 16'h0000, 1'b0);
        // highest address is out of range, so it reads as zero
        add_row(ACT_READ,   8'h00, 11'h7FF, 1, 1'b1, 11'd0, 16'h0000, 1'b0);
        add_row(ACT_PUT,    8'h41, 11'd0,   1, 1'b1, 11'd1, 16'h0000, 1'b0);
        add_row(ACT_READ,   8'h00, 11'd0,   1, 1'b1, 11'd1, 16'h0141, 1'b0);
        // clear blanks the lot and homes the cursor
        add_row(ACT_CLEAR,  8'h00, 11'd0,   1, 1'b1, 11'd0, 16'h0000, 1'b0);
        add_row(ACT_READ,   8'h00, 11'd0,   1, 1'b1, 11'd0, 16'h0120, 1'b0);
        add_row(ACT_READ,   8'h00, 11'd1999, 1, 1'b1, 11'd0, 16'h0120, 1'b0);
        // character extremes
        add_row(ACT_PUT,    8'hFF, 11'd0,   1, 1'b1, 11'd1, 16'h0000, 1'b0);
        add_row(ACT_PUT,    8'h00, 11'd0,   1, 1'b1, 11'd2, 16'h0000, 1'b0);
        add_row(ACT_READ,   8'h00, 11'd0,   1, 1'b1, 11'd2, 16'h01FF, 1'b0);
        add_row(ACT_READ,   8'h00, 11'd1,   1, 1'b1, 11'd2, 16'h0100, 1'b0);
        add_row(ACT_PUT,    NEWLINE_CODE, 11'd0, 1, 1'b1, 11'd80, 16'h0000, 1'b0);
        // first address past the end
        add_row(ACT_READ,   8'h00, 11'd2000, 1, 1'b1, 11'd80, 16'h0000, 1'b0);
        // walk down to the bottom row
        add_row(ACT_PUT,    NEWLINE_CODE, 11'd0, 23, 1'b0, '0, '0, 1'b0);
        add_row(ACT_PUT,    8'h7E, 11'd0,   1, 1'b0, '0, '0, 1'b0);
        // newline on the bottom row parks the cursor past the end
        add_row(ACT_PUT,    NEWLINE_CODE, 11'd0, 1, 1'b1, 11'd2000, 16'h0000, 1'b0);
        add_row(ACT_READ,   8'h00, 11'd1920, 1, 1'b1, 11'd2000, 16'h017E, 1'b0);
        // next put scrolls first, then lands at the start of the bottom row
        add_row(ACT_PUT,    8'h5A, 11'd0,   1, 1'b1, 11'd1921, 16'h0000, 1'b1);
        add_row(ACT_READ,   8'h00, 11'd1840, 1, 1'b1, 11'd1921, 16'h017E, 1'b0);
        add_row(ACT_READ,   8'h00, 11'd1920, 1, 1'b1, 11'd1921, 16'h015A, 1'b0);
        add_row(ACT_READ,   8'h00, 11'd1921, 1, 1'b1, 11'd1921, 16'h0120, 1'b0);
        add_row(ACT_PUT,    NEWLINE_CODE, 11'd0, 1, 1'b0, '0, '0, 1'b0);
        // scroll followed by a newline leaves the cursor past the end again
        add_row(ACT_PUT,    NEWLINE_CODE, 11'd0, 1, 1'b1, 11'd2000, 16'h0000, 1'b1);
        add_row(ACT_READ,   8'h00, 11'd1999, 1, 1'b1, 11'd2000, 16'h0120, 1'b0);
        add_row(ACT_UNUSED, 8'h00, 11'd0,   1, 1'b1, 11'd2000, 16'h0000, 1'b0);

        // reset held low from the start, released on a falling edge
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[r]) begin
            repeat (directed_rows[r].repeats)
                send_word(directed_rows[r].word, directed_rows[r].typed,
                          directed_rows[r].result);
        end

        // random phases, each under its own attribute; zero and all-ones come first
        for (int unsigned p = 0; p < PHASES; p++) begin
            wait_drained();
            attr = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : ATTR_W'($urandom_range(255));
            write_attribute(attr);
            quiet_run = (p == 1);   // one long stretch with no idling at all
            // mostly short lines so scrolling comes often, some phases with long ones
            newline_odds = (p == 1 || p == 4) ? 40 : 6;
            for (int unsigned k = 0; k < RANDOM_WORDS / PHASES; k++) begin
                w = random_word(newline_odds);
                send_word(w, 1'b0, '0);
            end
            quiet_run = 1'b0;
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
